### src/upd_pkg.sv
// Package for the URL percent decoder: character codes, the command record that
// travels from the front to the back, and the hex digit classifier.
// Used by upd_front, upd_queue, upd_back and url_percent_decoder_top.
package upd_pkg;

    // Character codes.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIG_LO  = 8'h30;
    localparam logic [7:0] CH_DIG_HI  = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;

    // Offsets that turn a letter digit into its value (10 to 15).
    localparam logic [7:0] LOW_OFFSET = 8'h57;
    localparam logic [7:0] UP_OFFSET  = 8'h37;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Number of output beats that one input byte can cause.
    localparam int MAX_BEATS = 3;

    // One command: up to three output bytes, already with plus mapped to space.
    typedef struct packed {
        logic [1:0]                 cnt;
        logic [MAX_BEATS-1:0][7:0]  bytes;
        logic                       last;
    } upd_cmd_t;

    // Status of the front, seen by the top level.
    typedef struct packed {
        logic escape_idle;
        logic push;
    } front_stat_t;

    // Hex digit check: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        diff = 8'h00;
        res  = 5'h00;
        if (c inside {[CH_DIG_LO:CH_DIG_HI]})
        begin
            diff = c - CH_DIG_LO;
            res  = {1'b1, diff[3:0]};
        end
        else if (c inside {[CH_LOW_A:CH_LOW_F]})
        begin
            diff = c - LOW_OFFSET;
            res  = {1'b1, diff[3:0]};
        end
        else if (c inside {[CH_UP_A:CH_UP_F]})
        begin
            diff = c - UP_OFFSET;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

    // Every emitted plus sign becomes a space.
    function automatic logic [7:0] map_plus(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

### src/url_percent_decoder_top.sv
// Top level of the URL percent decoder: front, command queue and back.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// The decoder takes one byte of a URL-encoded string per cycle while in_ready
// is high and sends out the decoded bytes, with out_last on the final byte of
// each string. A plain byte gives one beat; a '%' and a first hex digit are
// held and give no beat, the second digit gives the decoded byte. An escape
// broken by a non-hex byte or by the end of the string flushes the held
// characters literally, so that one input byte gives one to three beats;
// the back sends one beat per cycle while out_ready is high, and the command
// queue of QUEUE_DEPTH entries lets the input side go on until it fills. Every
// output plus sign, also one spelled by %2B, comes out as a space. The first
// beat of an accepted byte is offered once its command has passed through the
// queue and been loaded into the back's output register.
module url_percent_decoder_top #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    upd_pkg::upd_cmd_t    front_cmd;
    upd_pkg::upd_cmd_t    head_cmd;
    upd_pkg::front_stat_t front_stat;
    logic                 head_valid;
    logic                 q_full;
    logic                 pop;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    // Front: classify bytes into commands.
    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .cmd      (front_cmd),
        .stat     (front_stat)
    );

    // Queue between front and back.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_stat.push),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .full       (q_full),
        .count      (q_count)
    );

    // Back: send out the bytes of each command.
    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

    // The queue never holds more commands than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("command queue over its depth");

    // The back only takes a command that the queue holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_count != '0))
    else $error("pop from an empty command queue");

    // The end of a string always leaves no escape pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> front_stat.escape_idle)
    else $error("escape still pending after the last byte");

    // A push into a full queue can not happen.
    assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.push |-> !q_full)
    else $error("push into a full command queue");

endmodule

### src/upd_front.sv
// Front of the URL percent decoder: accepts input bytes, tracks the escape state
// and turns each byte into a command of zero to three output bytes.
// Depends on upd_pkg.
module upd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output upd_pkg::upd_cmd_t cmd,
    output upd_pkg::front_stat_t stat
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_DIGIT   = 2'd2
    } phase_t;

    phase_t     phase_reg,      phase_next;
    logic [3:0] held_digit_reg, held_digit_next;
    logic [7:0] held_char_reg,  held_char_next;

    logic [4:0] hex;
    logic       is_hex;
    logic       accept;
    logic [1:0] prefix;
    logic       run_plain;
    logic       plain_emits;

    assign hex      = upd_pkg::hex_value(in_byte);
    assign is_hex   = hex[4];
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // A plain byte is swallowed only when it opens an escape before the end.
    assign plain_emits = !((in_byte == upd_pkg::CH_PERCENT) && !in_last);

    // Classify the byte against the pending escape.
    always_comb
    begin
        phase_next      = phase_reg;
        held_digit_next = held_digit_reg;
        held_char_next  = held_char_reg;
        prefix          = 2'd0;
        run_plain       = 1'b0;
        cmd.cnt         = 2'd0;
        cmd.bytes       = '0;
        cmd.last        = in_last;
        case (phase_reg)
            PH_PERCENT:
            begin
                if (is_hex && !in_last)
                begin
                    phase_next      = PH_DIGIT;
                    held_digit_next = hex[3:0];
                    held_char_next  = in_byte;
                end
                else
                begin
                    cmd.bytes[0] = upd_pkg::CH_PERCENT;
                    prefix       = 2'd1;
                    run_plain    = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (is_hex)
                begin
                    cmd.bytes[0] = upd_pkg::map_plus({held_digit_reg, hex[3:0]});
                    cmd.cnt      = 2'd1;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    cmd.bytes[0] = upd_pkg::CH_PERCENT;
                    cmd.bytes[1] = held_char_reg;
                    prefix       = 2'd2;
                    run_plain    = 1'b1;
                end
            end
            default:
            begin
                run_plain = 1'b1;
            end
        endcase

        // Plain handling of the byte after any flushed escape characters.
        if (run_plain)
        begin
            if (plain_emits)
            begin
                phase_next        = PH_IDLE;
                cmd.bytes[prefix] = upd_pkg::map_plus(in_byte);
                cmd.cnt           = prefix + 2'd1;
            end
            else
            begin
                phase_next = PH_PERCENT;
                cmd.cnt    = prefix;
            end
        end
    end

    assign stat.push        = accept && (cmd.cnt != 2'd0);
    assign stat.escape_idle = (phase_reg == PH_IDLE);

    // Escape state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_digit_reg <= 4'h0;
            held_char_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            held_digit_reg <= held_digit_next;
            held_char_reg  <= held_char_next;
        end
    end

endmodule

### src/upd_queue.sv
// Command queue between the front and the back of the URL percent decoder.
// A small circular buffer with a fill count. Depends on upd_pkg.
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  upd_pkg::upd_cmd_t             push_cmd,
    input  logic                          pop,
    output upd_pkg::upd_cmd_t             head_cmd,
    output logic                          head_valid,
    output logic                          full,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_pkg::upd_cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign head_cmd   = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign count      = count_reg;

    // Pointer and fill count update with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/upd_back.sv
// Back of the URL percent decoder: takes commands from the queue and sends
// their bytes out one beat per cycle while out_ready is high. Depends on upd_pkg.
module upd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  upd_pkg::upd_cmd_t head_cmd,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    upd_pkg::upd_cmd_t cur_reg;
    logic              cur_valid_reg;
    logic [1:0]        idx_reg;
    logic              final_beat;
    logic              done;
    logic              load;

    assign final_beat = (idx_reg == (cur_reg.cnt - 2'd1));
    assign done       = cur_valid_reg && out_ready && final_beat;
    assign load       = !cur_valid_reg || done;
    assign pop        = load && head_valid;

    assign out_valid = cur_valid_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_last  = cur_reg.last && final_beat;

    // Beat sequencing over the current command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            cur_valid_reg <= head_valid;
            idx_reg       <= 2'd0;
        end
        else if (out_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_cmd;
        end
    end

endmodule
